// ===== rtl/tfd_pkg.sv =====
// Shared types and constants of the round-robin task dispatcher.
package tfd_pkg;

	localparam int TFD_MAX_WORKERS = 16;
	localparam int TFD_QUEUE_DEPTH = 16;

	localparam int PAYLOAD_W = 32;
	localparam int HANDLER_W = 8;
	localparam int IDX_W     = 4;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 5;
	localparam int ACTIVE_W  = 5;
	localparam int DONE_CNT_W = 32;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	localparam logic [ACTIVE_W-1:0]  ACTIVE_RST  = 5'd16;
	localparam logic [HANDLER_W-1:0] HANDLER_RST = 8'd1;

	localparam logic FUNC_SUBMIT = 1'b0;
	localparam logic FUNC_DONE   = 1'b1;

	localparam logic REG_ACTIVE  = 1'b0;
	localparam logic REG_DEFAULT = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DISPATCHED = 3'd0,
		ST_QUEUED     = 3'd1,
		ST_DROPPED    = 3'd2,
		ST_FREED      = 3'd3,
		ST_BADWORKER  = 3'd4
	} tfd_status_t;

	typedef struct packed {
		logic rd;
		logic push;
		logic pop;
	} tfd_qcmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} tfd_qstat_t;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] payload;
		logic [HANDLER_W-1:0] handler;
	} tfd_qentry_t;

endpackage

// ===== rtl/tfd_queue.sv =====
// Task FIFO: one synchronous memory of payload and handler with head, tail and fill.
module tfd_queue import tfd_pkg::*; #(
	parameter int QUEUE_DEPTH = TFD_QUEUE_DEPTH,
	localparam int PW = $clog2(QUEUE_DEPTH),
	localparam int FW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tfd_qcmd_t            cmd,
	input  logic [PAYLOAD_W-1:0] push_payload,
	input  logic [HANDLER_W-1:0] push_handler,
	output logic [PAYLOAD_W-1:0] head_payload,
	output logic [HANDLER_W-1:0] head_handler,
	output logic [FW-1:0]        fill,
	output tfd_qstat_t           qstat
);

	tfd_qentry_t mem [QUEUE_DEPTH];
	tfd_qentry_t rd_s1;
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [FW-1:0] fill_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_q] <= '{payload: push_payload, handler: push_handler};
		end
		if (cmd.rd) begin
			rd_s1 <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.push) begin
				tail_q <= (tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PW'(1);
			end
			if (cmd.pop) begin
				head_q <= (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PW'(1);
			end
			if (cmd.push && !cmd.pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (cmd.pop && !cmd.push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	assign head_payload = rd_s1.payload;
	assign head_handler = rd_s1.handler;
	assign fill         = fill_q;
	assign qstat.empty  = (fill_q == '0);
	assign qstat.full   = (fill_q == FW'(QUEUE_DEPTH));

endmodule

// ===== rtl/task_fifo_round_robin_dispatcher.sv =====
// Round-robin task dispatcher: task FIFO, worker idle flags and per-worker completion counters.
// An event is accepted when start is high and busy is low. The accept edge launches reads of
// the queue head and of the worker's completion counter, both memories with a registered read.
// In S_RUN the round-robin pointer is first reduced by active_workers until it lies below that
// register, normally not needed and only after that register was lowered; then the state is
// updated and the result registered, which is shown for one cycle with done high. busy is high
// from the accept edge until the result is registered. A new event can be accepted in the cycle
// that shows done, not before. Results cannot be stalled: sample them when done is high.
module task_fifo_round_robin_dispatcher import tfd_pkg::*; #(
	parameter int MAX_WORKERS = TFD_MAX_WORKERS,
	parameter int QUEUE_DEPTH = TFD_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  func,
	input  logic [PAYLOAD_W-1:0]  task_payload,
	input  logic [HANDLER_W-1:0]  handler_id,
	input  logic [IDX_W-1:0]      worker_index,
	output logic                  done,
	output logic [STATUS_W-1:0]   status,
	output logic [IDX_W-1:0]      dispatch_worker,
	output logic [PAYLOAD_W-1:0]  dispatch_payload,
	output logic [HANDLER_W-1:0]  dispatch_handler,
	output logic [COUNT_W-1:0]    queue_count,
	output logic [DONE_CNT_W-1:0] worker_done_count,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready
);

	localparam int WW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int NW = $clog2(MAX_WORKERS + 1);
	localparam int CW = (NW > IDX_W) ? NW : IDX_W;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t state_q;

	logic [ACTIVE_W-1:0]  active_q;
	logic [HANDLER_W-1:0] def_handler_q;

	logic                 func_q;
	logic [PAYLOAD_W-1:0] payload_q;
	logic [HANDLER_W-1:0] handler_q;
	logic [IDX_W-1:0]     widx_q;
	logic [WW-1:0]        mod_q;
	logic [WW-1:0]        search_start_q;
	logic [MAX_WORKERS-1:0] idle_q;
	logic [MAX_WORKERS-1:0] cnt_vld_q;

	logic                  done_q;
	tfd_status_t           status_q;
	logic [IDX_W-1:0]      disp_w_q;
	logic [PAYLOAD_W-1:0]  disp_p_q;
	logic [HANDLER_W-1:0]  disp_h_q;
	logic [COUNT_W-1:0]    qcount_q;
	logic [DONE_CNT_W-1:0] done_cnt_q;

	logic [DONE_CNT_W-1:0] cnt_mem [MAX_WORKERS];
	logic [DONE_CNT_W-1:0] cnt_rd_s1;
	logic                  cnt_vld_s1;

	logic accept;
	logic cfg_wr;
	logic [NW-1:0] n_used;
	logic mod_ok;
	logic run_go;
	logic [WW-1:0] widx_in_w;
	logic [WW-1:0] widx_w;
	logic bad_worker;

	logic [MAX_WORKERS-1:0] idle_eff;
	logic [MAX_WORKERS-1:0] idle_next;
	logic [MAX_WORKERS-1:0] cand;
	logic [MAX_WORKERS-1:0] cand_hi;
	logic [MAX_WORKERS-1:0] sel;
	logic found;
	logic [WW-1:0] pick;
	logic [NW-1:0] pick_inc;
	logic [WW-1:0] next_start;

	tfd_qcmd_t            qcmd;
	tfd_qstat_t           qstat;
	logic [PAYLOAD_W-1:0] head_payload;
	logic [HANDLER_W-1:0] head_handler;
	logic [FW-1:0]        qfill;

	tfd_status_t           st_d;
	logic [PAYLOAD_W-1:0]  disp_p_d;
	logic [HANDLER_W-1:0]  disp_h_d;
	logic [DONE_CNT_W-1:0] cnt_new;
	logic [DONE_CNT_W-1:0] done_cnt_d;
	logic [FW-1:0]         fill_next;
	logic                  q_push;
	logic                  q_pop;
	logic                  dispatch;
	logic                  worker_free;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DEFAULT) ? APB_DW'(def_handler_q) : APB_DW'(active_q);

	always_comb begin
		if (active_q == '0) begin
			n_used = NW'(1);
		end else if (int'(active_q) > MAX_WORKERS) begin
			n_used = NW'(MAX_WORKERS);
		end else begin
			n_used = NW'(active_q);
		end
	end

	assign mod_ok     = (NW'(mod_q) < n_used);
	assign run_go     = (state_q == S_RUN) && mod_ok;
	assign widx_in_w  = WW'(worker_index);
	assign widx_w     = WW'(widx_q);
	assign bad_worker = (CW'(widx_q) >= CW'(n_used));

	// round-robin idle search from mod_q, wrapping at the active count
	always_comb begin
		idle_eff = idle_q;
		if (func_q == FUNC_DONE && !bad_worker) begin
			idle_eff[widx_w] = 1'b1;
		end
		for (int i = 0; i < MAX_WORKERS; i++) begin
			cand[i]    = idle_eff[i] && (i < int'(n_used));
			cand_hi[i] = cand[i] && (i >= int'(mod_q));
		end
		found = |cand;
		sel   = (cand_hi != '0) ? cand_hi : cand;
		pick  = '0;
		for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
			if (sel[i]) begin
				pick = WW'(i);
			end
		end
		pick_inc   = NW'(pick) + NW'(1);
		next_start = (pick_inc == n_used) ? '0 : WW'(pick_inc);
	end

	assign cnt_new = (cnt_vld_s1 ? cnt_rd_s1 : '0) + DONE_CNT_W'(1);

	always_comb begin
		st_d        = ST_FREED;
		disp_p_d    = '0;
		disp_h_d    = '0;
		done_cnt_d  = '0;
		q_push      = 1'b0;
		q_pop       = 1'b0;
		dispatch    = 1'b0;
		worker_free = 1'b0;
		if (func_q == FUNC_SUBMIT) begin
			if (qstat.empty && found) begin
				dispatch = 1'b1;
				st_d     = ST_DISPATCHED;
				disp_p_d = payload_q;
				disp_h_d = (handler_q == '0) ? def_handler_q : handler_q;
			end else if (!qstat.full) begin
				q_push = 1'b1;
				st_d   = ST_QUEUED;
			end else begin
				st_d = ST_DROPPED;
			end
		end else begin
			if (bad_worker) begin
				st_d = ST_BADWORKER;
			end else begin
				worker_free = 1'b1;
				done_cnt_d  = cnt_new;
				if (!qstat.empty && found) begin
					q_pop    = 1'b1;
					dispatch = 1'b1;
					st_d     = ST_DISPATCHED;
					disp_p_d = head_payload;
					disp_h_d = head_handler;
				end
			end
		end
		if (q_push) begin
			fill_next = qfill + FW'(1);
		end else if (q_pop) begin
			fill_next = qfill - FW'(1);
		end else begin
			fill_next = qfill;
		end
	end

	// freed worker marked idle, then the chosen worker marked busy
	always_comb begin
		idle_next = idle_eff;
		if (dispatch) begin
			idle_next[pick] = 1'b0;
		end
	end

	assign qcmd.rd   = accept;
	assign qcmd.push = run_go && q_push;
	assign qcmd.pop  = run_go && q_pop;

	tfd_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (qcmd),
		.push_payload(payload_q),
		.push_handler((handler_q == '0) ? def_handler_q : handler_q),
		.head_payload(head_payload),
		.head_handler(head_handler),
		.fill        (qfill),
		.qstat       (qstat)
	);

	always_ff @(posedge clk) begin
		if (run_go && worker_free) begin
			cnt_mem[widx_w] <= cnt_new;
		end
		if (accept) begin
			cnt_rd_s1 <= cnt_mem[widx_in_w];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			active_q       <= ACTIVE_RST;
			def_handler_q  <= HANDLER_RST;
			func_q         <= FUNC_SUBMIT;
			payload_q      <= '0;
			handler_q      <= '0;
			widx_q         <= '0;
			mod_q          <= '0;
			search_start_q <= '0;
			idle_q         <= '1;
			cnt_vld_q      <= '0;
			cnt_vld_s1     <= 1'b0;
			done_q         <= 1'b0;
			status_q       <= ST_DISPATCHED;
			disp_w_q       <= '0;
			disp_p_q       <= '0;
			disp_h_q       <= '0;
			qcount_q       <= '0;
			done_cnt_q     <= '0;
		end else begin
			done_q <= run_go;
			if (cfg_wr) begin
				if (paddr[2] == REG_DEFAULT) begin
					def_handler_q <= pwdata[HANDLER_W-1:0];
				end else begin
					active_q <= pwdata[ACTIVE_W-1:0];
				end
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q     <= func;
						payload_q  <= task_payload;
						handler_q  <= handler_id;
						widx_q     <= worker_index;
						mod_q      <= search_start_q;
						cnt_vld_s1 <= cnt_vld_q[widx_in_w];
						state_q    <= S_RUN;
					end
				end
				S_RUN: begin
					if (!mod_ok) begin
						mod_q <= WW'(NW'(mod_q) - n_used);
					end else begin
						idle_q <= idle_next;
						if (worker_free) begin
							cnt_vld_q[widx_w] <= 1'b1;
						end
						if (dispatch) begin
							search_start_q <= next_start;
						end
						status_q   <= st_d;
						disp_w_q   <= dispatch ? IDX_W'(pick) : '0;
						disp_p_q   <= disp_p_d;
						disp_h_q   <= disp_h_d;
						qcount_q   <= COUNT_W'(fill_next);
						done_cnt_q <= done_cnt_d;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done              = done_q;
	assign status            = status_q;
	assign dispatch_worker   = disp_w_q;
	assign dispatch_payload  = disp_p_q;
	assign dispatch_handler  = disp_h_q;
	assign queue_count       = qcount_q;
	assign worker_done_count = done_cnt_q;

endmodule

// ===== tb/tb_task_fifo_round_robin_dispatcher.sv =====
// Self-checking testbench for the round-robin task dispatcher: directed and random events, scoreboard check.
`timescale 1ns / 1ps

module tb_task_fifo_round_robin_dispatcher;
	import tfd_pkg::*;

	localparam int WATCHDOG_LIMIT  = 500;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 193;
	localparam int QUIET_PHASE     = 6;
	localparam int PENDING_DEPTH   = 8;

	typedef struct {
		logic [STATUS_W-1:0]   status;
		logic [IDX_W-1:0]      worker;
		logic [PAYLOAD_W-1:0]  payload;
		logic [HANDLER_W-1:0]  handler;
		logic [COUNT_W-1:0]    qcount;
		logic [DONE_CNT_W-1:0] done_count;
	} dispatch_result_t;

	class dispatch_scoreboard;
		logic [PAYLOAD_W-1:0]  q_payload [TFD_QUEUE_DEPTH];
		logic [HANDLER_W-1:0]  q_handler [TFD_QUEUE_DEPTH];
		int unsigned           q_head;
		int unsigned           q_tail;
		int unsigned           q_fill;
		bit                    worker_idle [TFD_MAX_WORKERS];
		int unsigned           rr_next;
		logic [DONE_CNT_W-1:0] completions [TFD_MAX_WORKERS];
		logic [ACTIVE_W-1:0]   active_reg;
		logic [HANDLER_W-1:0]  default_reg;
		dispatch_result_t      pend_buf [PENDING_DEPTH];
		int unsigned           pend_rd;
		int unsigned           pend_wr;
		int unsigned           pend_cnt;
		int                    errors;

		function new();
			q_head = 0;
			q_tail = 0;
			q_fill = 0;
			rr_next = 0;
			pend_rd = 0;
			pend_wr = 0;
			pend_cnt = 0;
			errors = 0;
			active_reg = ACTIVE_RST;
			default_reg = HANDLER_RST;
			for (int i = 0; i < TFD_MAX_WORKERS; i++) begin
				worker_idle[i] = 1'b1;
				completions[i] = '0;
			end
		endfunction

		function int unsigned used_count();
			int unsigned n;
			n = active_reg;
			if (n == 0) n = 1;
			if (n > TFD_MAX_WORKERS) n = TFD_MAX_WORKERS;
			return n;
		endfunction

		function bit find_idle(output int unsigned who);
			int unsigned n;
			int unsigned first;
			n = used_count();
			first = rr_next % n;
			who = 0;
			for (int unsigned i = 0; i < n; i++) begin
				if (worker_idle[(first + i) % n]) begin
					who = (first + i) % n;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void give_task(int unsigned w, logic [PAYLOAD_W-1:0] p, logic [HANDLER_W-1:0] h,
				inout dispatch_result_t r);
			worker_idle[w] = 1'b0;
			rr_next = (w + 1) % used_count();
			r.status = ST_DISPATCHED;
			r.worker = w[IDX_W-1:0];
			r.payload = p;
			r.handler = h;
		endfunction

		function void set_config(logic sel, logic [APB_DW-1:0] data);
			if (sel == REG_ACTIVE) active_reg = data[ACTIVE_W-1:0];
			else default_reg = data[HANDLER_W-1:0];
		endfunction

		function logic [APB_DW-1:0] config_value(logic sel);
			if (sel == REG_ACTIVE) return {{(APB_DW-ACTIVE_W){1'b0}}, active_reg};
			return {{(APB_DW-HANDLER_W){1'b0}}, default_reg};
		endfunction

		function void add_expected(dispatch_result_t r);
			if (pend_cnt == PENDING_DEPTH) begin
				errors++;
				$display("%0t expected results overflow: expected at most %0d, actual %0d", $time,
					PENDING_DEPTH, pend_cnt + 1);
				return;
			end
			pend_buf[pend_wr] = r;
			pend_wr = (pend_wr + 1) % PENDING_DEPTH;
			pend_cnt++;
		endfunction

		function void note_event(logic f, logic [PAYLOAD_W-1:0] payload,
				logic [HANDLER_W-1:0] handler, logic [IDX_W-1:0] widx);
			dispatch_result_t r;
			int unsigned w;
			logic [HANDLER_W-1:0] h;
			r.status = ST_DISPATCHED;
			r.worker = '0;
			r.payload = '0;
			r.handler = '0;
			r.qcount = '0;
			r.done_count = '0;
			if (f == FUNC_SUBMIT) begin
				h = (handler == '0) ? default_reg : handler;
				if (q_fill == 0 && find_idle(w)) begin
					give_task(w, payload, h, r);
				end else if (q_fill < TFD_QUEUE_DEPTH) begin
					q_payload[q_tail] = payload;
					q_handler[q_tail] = h;
					q_tail = (q_tail + 1) % TFD_QUEUE_DEPTH;
					q_fill++;
					r.status = ST_QUEUED;
				end else begin
					r.status = ST_DROPPED;
				end
			end else if (widx >= used_count()) begin
				r.status = ST_BADWORKER;
			end else begin
				worker_idle[widx] = 1'b1;
				completions[widx] = completions[widx] + 1'b1;
				r.done_count = completions[widx];
				if (q_fill > 0 && find_idle(w)) begin
					give_task(w, q_payload[q_head], q_handler[q_head], r);
					q_head = (q_head + 1) % TFD_QUEUE_DEPTH;
					q_fill--;
				end else begin
					r.status = ST_FREED;
				end
			end
			r.qcount = q_fill[COUNT_W-1:0];
			add_expected(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_result(dispatch_result_t got);
			dispatch_result_t want;
			if (pend_cnt == 0) begin
				errors++;
				$display("%0t unexpected result: expected none, actual status %h", $time, got.status);
				return;
			end
			want = pend_buf[pend_rd];
			pend_rd = (pend_rd + 1) % PENDING_DEPTH;
			pend_cnt--;
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("dispatch_worker", 32'(want.worker), 32'(got.worker));
			compare_field("dispatch_payload", want.payload, got.payload);
			compare_field("dispatch_handler", 32'(want.handler), 32'(got.handler));
			compare_field("queue_count", 32'(want.qcount), 32'(got.qcount));
			compare_field("worker_done_count", want.done_count, got.done_count);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  func;
	logic [PAYLOAD_W-1:0]  task_payload;
	logic [HANDLER_W-1:0]  handler_id;
	logic [IDX_W-1:0]      worker_index;
	logic                  done;
	logic [STATUS_W-1:0]   status;
	logic [IDX_W-1:0]      dispatch_worker;
	logic [PAYLOAD_W-1:0]  dispatch_payload;
	logic [HANDLER_W-1:0]  dispatch_handler;
	logic [COUNT_W-1:0]    queue_count;
	logic [DONE_CNT_W-1:0] worker_done_count;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_AW-1:0]     paddr;
	logic [APB_DW-1:0]     pwdata;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;

	dispatch_scoreboard sb = new();
	int idle_cycles = 0;

	task_fifo_round_robin_dispatcher uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.task_payload(task_payload),
		.handler_id(handler_id),
		.worker_index(worker_index),
		.done(done),
		.status(status),
		.dispatch_worker(dispatch_worker),
		.dispatch_payload(dispatch_payload),
		.dispatch_handler(dispatch_handler),
		.queue_count(queue_count),
		.worker_done_count(worker_done_count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		dispatch_result_t seen;
		if (arst_n && done === 1'b1) begin
			seen.status = status;
			seen.worker = dispatch_worker;
			seen.payload = dispatch_payload;
			seen.handler = dispatch_handler;
			seen.qcount = queue_count;
			seen.done_count = worker_done_count;
			sb.check_result(seen);
		end
	end

	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1 || (psel && penable)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[task_fifo_round_robin_dispatcher] ERROR");
			$finish;
		end
	end

	// holds start until the transfer edge, then records the event
	task automatic send_item(input logic f, input logic [PAYLOAD_W-1:0] p,
			input logic [HANDLER_W-1:0] h, input logic [IDX_W-1:0] w);
		start <= 1'b1;
		func <= f;
		task_payload <= p;
		handler_id <= h;
		worker_index <= w;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_event(f, p, h, w);
	endtask

	task automatic pause_sender(input bit allow);
		if (allow && $urandom_range(99) < 30) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (sb.pend_cnt != 0 || busy !== 1'b0);
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_write(input logic sel, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_config(sel, data);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read_check(input logic sel);
		logic [APB_DW-1:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		want = sb.config_value(sel);
		if (prdata !== want) begin
			sb.errors++;
			$display("%0t mismatch prdata at %h: expected %h, actual %h", $time, {sel, 2'b00},
				want, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_registers(input logic [ACTIVE_W-1:0] act, input logic [HANDLER_W-1:0] dflt);
		apb_write(REG_ACTIVE, ($urandom & ~32'h1F) | act);
		apb_write(REG_DEFAULT, ($urandom & ~32'hFF) | dflt);
		apb_read_check(REG_ACTIVE);
		apb_read_check(REG_DEFAULT);
	endtask

	initial begin
		int act;
		int dflt;
		int submit_pct;
		int n;
		arst_n <= 1'b0;
		start <= 1'b0;
		func <= FUNC_SUBMIT;
		task_payload <= '0;
		handler_id <= '0;
		worker_index <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_read_check(REG_ACTIVE);
		apb_read_check(REG_DEFAULT);

		// reset settings: default handler, extremes, done on busy and idle workers
		send_item(FUNC_SUBMIT, 32'h0, 8'h00, 4'h0);
		send_item(FUNC_SUBMIT, 32'hFFFF_FFFF, 8'hFF, 4'hF);
		send_item(FUNC_DONE, 32'h0, 8'h00, 4'h0);
		send_item(FUNC_DONE, 32'h0, 8'h00, 4'hF);
		send_item(FUNC_DONE, 32'hFFFF_FFFF, 8'hFF, 4'h1);
		send_item(FUNC_DONE, 32'h0, 8'h00, 4'h1);
		drain_results();

		// active count zero, default handler zero, bad worker
		set_registers(5'd0, 8'd0);
		send_item(FUNC_SUBMIT, 32'h1234_5678, 8'h00, 4'h0);
		send_item(FUNC_SUBMIT, 32'hA5A5_A5A5, 8'h3C, 4'h0);
		send_item(FUNC_DONE, 32'h0, 8'h00, 4'h0);
		send_item(FUNC_DONE, 32'h0, 8'h00, 4'h5);
		drain_results();

		// active count above the maximum
		set_registers(5'd31, 8'd255);
		send_item(FUNC_SUBMIT, $urandom, 8'h00, 4'h0);
		send_item(FUNC_SUBMIT, $urandom, 8'h07, 4'h0);
		send_item(FUNC_SUBMIT, $urandom, 8'h00, 4'h0);
		send_item(FUNC_SUBMIT, $urandom, 8'h80, 4'h0);
		send_item(FUNC_SUBMIT, $urandom, 8'h01, 4'h0);
		drain_results();

		// lowered active count leaves a stale round-robin pointer
		apb_write(REG_ACTIVE, 32'd3);
		send_item(FUNC_DONE, 32'h0, 8'h00, 4'h1);
		send_item(FUNC_SUBMIT, $urandom, 8'h00, 4'h0);
		send_item(FUNC_DONE, 32'h0, 8'h00, 4'h7);
		send_item(FUNC_DONE, 32'h0, 8'h00, 4'h2);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			case (ph)
				0: act = 16;
				1: act = 1;
				2: act = 0;
				3: act = 31;
				4: act = 2;
				5: act = $urandom_range(15, 3);
				7: act = $urandom_range(31, 17);
				8: act = $urandom_range(16, 1);
				9: act = 5;
				default: act = 16;
			endcase
			case (ph % 3)
				0: dflt = 0;
				1: dflt = 255;
				default: dflt = $urandom_range(255);
			endcase
			set_registers(act[ACTIVE_W-1:0], dflt[HANDLER_W-1:0]);
			submit_pct = 50;
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (k % 40 == 0) begin
					case ($urandom_range(2))
						0: submit_pct = 20;
						1: submit_pct = 50;
						default: submit_pct = 85;
					endcase
				end
				n = sb.used_count();
				if ($urandom_range(99) < submit_pct)
					send_item(FUNC_SUBMIT, $urandom,
						($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255)),
						4'($urandom_range(15)));
				else
					send_item(FUNC_DONE, $urandom, 8'($urandom_range(255)),
						($urandom_range(99) < 85) ? 4'($urandom_range(n - 1)) :
						4'($urandom_range(15)));
				pause_sender(ph != QUIET_PHASE);
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pend_cnt == 0)
			$display("[task_fifo_round_robin_dispatcher] OK");
		else
			$display("[task_fifo_round_robin_dispatcher] ERROR");
		$finish;
	end

endmodule

// ===== task_fifo_round_robin_dispatcher.f =====
rtl/tfd_pkg.sv
rtl/tfd_queue.sv
rtl/task_fifo_round_robin_dispatcher.sv
tb/tb_task_fifo_round_robin_dispatcher.sv
